/* design/trd_pkg.sv */
// Shared types and constants for the tape image record deframer.
// Used by the front parser, the command queue, the result sequencer and the top level.
package trd_pkg;

	// Kind of one result item.
	typedef enum logic [2:0] {
		KIND_DATA = 3'd0,
		KIND_MARK = 3'd1,
		KIND_REND = 3'd2,
		KIND_EOM  = 3'd3,
		KIND_ERR  = 3'd4
	} kind_t;

	// Verdict on a record trailer.
	typedef enum logic [1:0] {
		TS_MATCH    = 2'd0,
		TS_MISMATCH = 2'd1,
		TS_TRUNC    = 2'd2
	} tstat_t;

	// Input operation codes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Header value that marks end of medium.
	localparam logic [31:0] EOM_MARK = 32'hffff_ffff;

	// Default depth of the queue between parser and sequencer.
	localparam int QUEUE_DEPTH_DEF = 4;

	// One queued command: a first result, and optionally a second one that
	// carries only a kind (end of medium or error).
	typedef struct packed {
		kind_t       kind0;
		logic [7:0]  out_byte;
		logic [31:0] record_length;
		tstat_t      tstat;
		logic        two;
		kind_t       kind1;
	} cmd_t;

endpackage

/* design/trd_front.sv */
// Front parser of the deframer: accepts image bytes, tracks the record phase
// and pushes result commands into the queue. Depends on trd_pkg.
module trd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  logic [7:0]       in_byte,
	input  logic             queue_full,
	output logic             push,
	output trd_pkg::cmd_t    push_cmd
);

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_DATA = 3'd1,
		PH_TRL  = 3'd2,
		PH_TRLP = 3'd3,
		PH_EOM  = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  byte_count_q, byte_count_d;
	logic [31:0] record_len_q, record_len_d;
	logic [31:0] bytes_left_q, bytes_left_d;
	logic [31:0] window_q, window_d;
	logic [31:0] win_sh;
	logic        accept;
	logic        trl_match;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	// Newest byte enters at the top, so the window reads little-endian.
	assign win_sh    = {in_byte, window_q[31:8]};
	assign trl_match = (win_sh == record_len_q);

	// Next state and the command for this transaction.
	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		record_len_d = record_len_q;
		bytes_left_d = bytes_left_q;
		window_d     = window_q;
		push         = 1'b0;
		push_cmd     = '0;
		if (accept) begin
			if (op == trd_pkg::OP_END) begin
				byte_count_d = '0;
				unique case (phase_q)
					PH_HDR: begin
						push           = 1'b1;
						push_cmd.kind0 = trd_pkg::KIND_EOM;
						phase_d        = PH_EOM;
					end
					PH_DATA: begin
						push           = 1'b1;
						push_cmd.kind0 = trd_pkg::KIND_ERR;
						phase_d        = PH_ERR;
					end
					PH_TRL, PH_TRLP: begin
						push                   = 1'b1;
						push_cmd.kind0         = trd_pkg::KIND_REND;
						push_cmd.record_length = record_len_q;
						push_cmd.tstat         = trd_pkg::TS_TRUNC;
						push_cmd.two           = 1'b1;
						push_cmd.kind1         = trd_pkg::KIND_EOM;
						phase_d                = PH_EOM;
					end
					default: begin
					end
				endcase
			end else begin
				unique case (phase_q)
					PH_HDR: begin
						window_d = win_sh;
						if (byte_count_q == 2'd3) begin
							byte_count_d = '0;
							if (win_sh == trd_pkg::EOM_MARK) begin
								push           = 1'b1;
								push_cmd.kind0 = trd_pkg::KIND_EOM;
								phase_d        = PH_EOM;
							end else if (win_sh == '0) begin
								push           = 1'b1;
								push_cmd.kind0 = trd_pkg::KIND_MARK;
							end else begin
								record_len_d = win_sh;
								bytes_left_d = win_sh;
								phase_d      = PH_DATA;
							end
						end else begin
							byte_count_d = byte_count_q + 2'd1;
						end
					end
					PH_DATA: begin
						push              = 1'b1;
						push_cmd.kind0    = trd_pkg::KIND_DATA;
						push_cmd.out_byte = in_byte;
						bytes_left_d      = bytes_left_q - 32'd1;
						if (bytes_left_q == 32'd1) begin
							phase_d      = PH_TRL;
							byte_count_d = '0;
						end
					end
					PH_TRL, PH_TRLP: begin
						window_d = win_sh;
						if (phase_q == PH_TRL && byte_count_q != 2'd3) begin
							byte_count_d = byte_count_q + 2'd1;
						end else if (phase_q == PH_TRL && record_len_q[0] && !trl_match) begin
							// Odd length without a match: the first byte was pad.
							phase_d      = PH_TRLP;
							byte_count_d = '0;
						end else begin
							// Trailer complete: close the record.
							byte_count_d           = '0;
							push                   = 1'b1;
							push_cmd.kind0         = trd_pkg::KIND_REND;
							push_cmd.record_length = record_len_q;
							if (trl_match) begin
								push_cmd.tstat = trd_pkg::TS_MATCH;
								phase_d        = PH_HDR;
							end else begin
								push_cmd.tstat = trd_pkg::TS_MISMATCH;
								push_cmd.two   = 1'b1;
								push_cmd.kind1 = trd_pkg::KIND_ERR;
								phase_d        = PH_ERR;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR;
			byte_count_q <= '0;
			record_len_q <= '0;
			bytes_left_q <= '0;
			window_q     <= '0;
		end else begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			record_len_q <= record_len_d;
			bytes_left_q <= bytes_left_d;
			window_q     <= window_d;
		end
	end

	// Once halted, the parser never leaves the halted phase.
	a_eom_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EOM) |=> (phase_q == PH_EOM))
		else $error("parser left end of medium");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |=> (phase_q == PH_ERR && !push))
		else $error("parser left error phase or produced output");

	// Data phase always holds a nonzero byte budget.
	a_data_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (bytes_left_q != '0))
		else $error("data phase with no bytes left");

endmodule

/* design/trd_queue.sv */
// Small command queue between the parser and the result sequencer.
// Flip-flop storage read at the head only. Depends on trd_pkg.
module trd_queue #(
	parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  trd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output trd_pkg::cmd_t pop_cmd,
	output logic          empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	trd_pkg::cmd_t    store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

/* design/trd_back.sv */
// Result sequencer: pops queued commands and drives result transactions
// from an output register, one or two results per command. Depends on trd_pkg.
module trd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  trd_pkg::cmd_t  pop_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     kind,
	output logic [7:0]     out_byte,
	output logic [31:0]    record_length,
	output logic [1:0]     trailer_status,
	output logic           last
);

	logic              out_valid_q;
	trd_pkg::kind_t    kind_q;
	logic [7:0]        out_byte_q;
	logic [31:0]       record_length_q;
	trd_pkg::tstat_t   tstat_q;
	logic              last_q;
	logic              pend_q;
	trd_pkg::kind_t    kind1_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;
	// A queued command is taken only when no second result is still owed.
	assign pop      = out_free && !pend_q && !empty;

	// Control: output valid and the owed second result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				pend_q      <= !empty && pop_cmd.two;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				kind_q          <= kind1_q;
				out_byte_q      <= '0;
				record_length_q <= '0;
				tstat_q         <= trd_pkg::TS_MATCH;
				last_q          <= 1'b1;
			end else if (!empty) begin
				kind_q          <= pop_cmd.kind0;
				out_byte_q      <= pop_cmd.out_byte;
				record_length_q <= pop_cmd.record_length;
				tstat_q         <= pop_cmd.tstat;
				last_q          <= !pop_cmd.two;
				kind1_q         <= pop_cmd.kind1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign out_byte       = out_byte_q;
	assign record_length  = record_length_q;
	assign trailer_status = tstat_q;
	assign last           = last_q;

	// An owed second result sits behind a shown first result that is not last.
	a_pend_behind_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (out_valid_q && !last_q && kind_q == trd_pkg::KIND_REND))
		else $error("second result owed without a record end in front");

	// Data and tapemark results are always the only result of their byte.
	a_single_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == trd_pkg::KIND_DATA || kind_q == trd_pkg::KIND_MARK))
		|-> last_q)
		else $error("data or tapemark result not marked last");

endmodule

/* design/tape_image_record_deframer_core.sv */
// Top level of the tape image record deframer: parser, command queue and
// result sequencer. Depends on trd_pkg, trd_front, trd_queue and trd_back.
//
// The deframer takes one image byte (or the end-of-image marker) per cycle and
// gives results on a separate valid/ready channel. Each accepted byte yields zero
// or one result, except a record end with a bad or truncated trailer, which yields
// the record end and then an error or end-of-medium result from one command; the
// parser is halted when it queues that command. The parser decides each byte as it is
// accepted, and a queue of QUEUE_DEPTH commands lets it keep accepting while
// results wait at the output, so the input stalls only when the consumer holds
// off long enough to fill the queue. After end of medium or an error all further
// input is accepted and dropped until reset.
module tape_image_record_deframer_core #(
	parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic [31:0] record_length,
	output logic [1:0]  trailer_status,
	output logic        last
);

	logic          push;
	trd_pkg::cmd_t push_cmd;
	logic          queue_full;
	logic          pop;
	trd_pkg::cmd_t pop_cmd;
	logic          queue_empty;

	// Parser.
	trd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.in_byte    (in_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Command queue.
	trd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (queue_empty)
	);

	// Result sequencer.
	trd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (queue_empty),
		.pop_cmd        (pop_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.out_byte       (out_byte),
		.record_length  (record_length),
		.trailer_status (trailer_status),
		.last           (last)
	);

endmodule
